[hw/rtl/accumulator_alu_with_flags_defines.svh]
// Assertion macros shared by the accumulator ALU RTL.
`ifndef ACCUMULATOR_ALU_WITH_FLAGS_DEFINES_SVH
`define ACCUMULATOR_ALU_WITH_FLAGS_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ACC_ALU_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ACC_ALU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/acc_alu_pkg.sv]
// Package: opcodes and architectural state type for the accumulator ALU.
package acc_alu_pkg;

  typedef enum logic [3:0] {
    OP_ADD = 4'd0,
    OP_SUB = 4'd1,
    OP_CMP = 4'd2,
    OP_AND = 4'd3,
    OP_XOR = 4'd4,
    OP_OR  = 4'd5,
    OP_INR = 4'd6,
    OP_DCR = 4'd7,
    OP_INX = 4'd8,
    OP_DCX = 4'd9,
    OP_DAD = 4'd10
  } acc_alu_op_t;

  // Accumulator and the five condition flags.
  typedef struct packed {
    logic [7:0] acc;
    logic       zero;
    logic       sign;
    logic       parity;
    logic       carry;
    logic       aux_carry;
  } acc_alu_state_t;

endpackage

[hw/rtl/acc_alu_core.sv]
// Combinational datapath: one ALU operation against the current state.
module acc_alu_core
  import acc_alu_pkg::*;
(
  input  logic [3:0]     op,
  input  logic [7:0]     operand,
  input  logic [15:0]    pair_value,
  input  logic [15:0]    hl_value,
  input  acc_alu_state_t state,
  output acc_alu_state_t state_nxt,
  output logic [7:0]     byte_res,
  output logic [15:0]    pair_res
);

  logic [8:0]  add_sum;
  logic [4:0]  nib_sum;
  logic [7:0]  sub_diff;
  logic [16:0] dad_sum;
  logic        zsp_en;
  logic [7:0]  zsp_val;

  assign add_sum  = {1'b0, state.acc} + {1'b0, operand};
  assign nib_sum  = {1'b0, state.acc[3:0]} + {1'b0, operand[3:0]};
  assign sub_diff = state.acc - operand;
  assign dad_sum  = {1'b0, hl_value} + {1'b0, pair_value};

  always_comb begin
    state_nxt = state;
    byte_res  = '0;
    pair_res  = '0;
    zsp_en    = 1'b0;
    zsp_val   = '0;
    unique case (op)
      OP_ADD: begin
        state_nxt.acc       = add_sum[7:0];
        state_nxt.carry     = add_sum[8];
        state_nxt.aux_carry = nib_sum[4];
        zsp_en              = 1'b1;
        zsp_val             = add_sum[7:0];
      end
      OP_SUB, OP_CMP: begin
        // carry is the borrow; aux carry is the nibble carry of A + ~D + 1
        if (op == OP_SUB) begin
          state_nxt.acc = sub_diff;
        end
        state_nxt.carry     = (state.acc < operand);
        state_nxt.aux_carry = (state.acc[3:0] >= operand[3:0]);
        zsp_en              = 1'b1;
        zsp_val             = sub_diff;
      end
      OP_AND, OP_XOR, OP_OR: begin
        unique case (op)
          OP_AND:  zsp_val = state.acc & operand;
          OP_XOR:  zsp_val = state.acc ^ operand;
          default: zsp_val = state.acc | operand;
        endcase
        state_nxt.acc       = zsp_val;
        state_nxt.carry     = 1'b0;
        state_nxt.aux_carry = 1'b0;
        zsp_en              = 1'b1;
      end
      OP_INR: begin
        byte_res            = operand + 8'd1;
        state_nxt.aux_carry = (operand[3:0] == 4'hf);
        zsp_en              = 1'b1;
        zsp_val             = byte_res;
      end
      OP_DCR: begin
        byte_res            = operand - 8'd1;
        state_nxt.aux_carry = (operand[3:0] != 4'h0);
        zsp_en              = 1'b1;
        zsp_val             = byte_res;
      end
      OP_INX: pair_res = pair_value + 16'd1;
      OP_DCX: pair_res = pair_value - 16'd1;
      OP_DAD: begin
        pair_res        = dad_sum[15:0];
        state_nxt.carry = dad_sum[16];
      end
      default: begin
        // unused opcodes: state held, empty byte and pair results
      end
    endcase
    if (zsp_en) begin
      state_nxt.zero   = (zsp_val == 8'h00);
      state_nxt.sign   = zsp_val[7];
      state_nxt.parity = ~^zsp_val;
    end
  end

endmodule

[hw/rtl/accumulator_alu_with_flags.sv]
// Top level: accumulator ALU with condition flags, input stage and result register.
//
//   channel | valid     | ready     | payload
//   --------+-----------+-----------+------------------------------------------
//   in      | in_valid  | in_ready  | req_type, operand, pair_value, hl_value
//   out     | out_valid | out_ready | acc_out, byte_result, pair_result, flags
//
// An accepted input loads the input register; the ALU logic is loaded into the
// result register when the input stage advances, which waits on a stalled output.
// Throughput is one item per cycle while the output is not stalled;
// the accumulator/flag update loop closes through the combinational core.
// Reset (rst_n low, synchronous) empties both stages and clears accumulator and flags.
// A stalled output holds the result register; the input stage then fills and
// in_ready drops until out_ready returns.
`include "accumulator_alu_with_flags_defines.svh"

module accumulator_alu_with_flags
  import acc_alu_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  in_req_type,
  input  logic [7:0]  in_operand,
  input  logic [15:0] in_pair_value,
  input  logic [15:0] in_hl_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_acc_out,
  output logic [7:0]  out_byte_result,
  output logic [15:0] out_pair_result,
  output logic        out_zero_flag,
  output logic        out_sign_flag,
  output logic        out_parity_flag,
  output logic        out_carry_flag,
  output logic        out_aux_carry_flag
);

  // input stage
  logic        s1_valid_r;
  logic [3:0]  s1_op_r;
  logic [7:0]  s1_operand_r;
  logic [15:0] s1_pair_r;
  logic [15:0] s1_hl_r;

  // architectural state and result register
  acc_alu_state_t state_r;
  acc_alu_state_t state_nxt;
  logic           out_valid_r;
  acc_alu_state_t out_state_r;
  logic [7:0]     out_byte_r;
  logic [15:0]    out_pair_r;
  logic [7:0]     byte_nxt;
  logic [15:0]    pair_nxt;

  logic out_adv;
  logic s1_adv;

  // The result register frees when empty or being taken; the input stage
  // moves whenever it holds an item and the result register frees.
  assign out_adv  = !out_valid_r || out_ready;
  assign s1_adv   = s1_valid_r && out_adv;
  assign in_ready = !s1_valid_r || out_adv;

  acc_alu_core u_core (
    .op         (s1_op_r),
    .operand    (s1_operand_r),
    .pair_value (s1_pair_r),
    .hl_value   (s1_hl_r),
    .state      (state_r),
    .state_nxt  (state_nxt),
    .byte_res   (byte_nxt),
    .pair_res   (pair_nxt)
  );

  // Control: stage valids and the accumulator/flags, which reset clears.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= '0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (out_adv) begin
        out_valid_r <= s1_valid_r;
      end
      // commit state only when the item moves into the result register
      if (s1_adv) begin
        state_r <= state_nxt;
      end
    end
  end

  // Payload: input fields load on accept, results load on advance; hold otherwise.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_op_r      <= in_req_type;
      s1_operand_r <= in_operand;
      s1_pair_r    <= in_pair_value;
      s1_hl_r      <= in_hl_value;
    end
    if (s1_adv) begin
      out_state_r <= state_nxt;
      out_byte_r  <= byte_nxt;
      out_pair_r  <= pair_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_acc_out        = out_state_r.acc;
  assign out_byte_result    = out_byte_r;
  assign out_pair_result    = out_pair_r;
  assign out_zero_flag      = out_state_r.zero;
  assign out_sign_flag      = out_state_r.sign;
  assign out_parity_flag    = out_state_r.parity;
  assign out_carry_flag     = out_state_r.carry;
  assign out_aux_carry_flag = out_state_r.aux_carry;

  // A shown result always mirrors the committed accumulator and flags.
  `ACC_ALU_ASSERT_SAME(a_out_matches_state, clk, rst_n, out_valid_r, out_state_r == state_r, "result register differs from committed state")

  // INX and DCX leave every flag untouched.
  `ACC_ALU_ASSERT_NEXT(a_pair_ops_keep_flags, clk, rst_n, s1_adv && (s1_op_r == OP_INX || s1_op_r == OP_DCX), state_r[4:0] == $past(state_r[4:0]), "INX/DCX changed a flag")

  // Byte and pair results never both carry data.
  `ACC_ALU_ASSERT_SAME(a_results_exclusive, clk, rst_n, out_valid_r && out_pair_r != 16'h0000, out_byte_r == 8'h00, "byte and pair result both set")

  // A full input stage behind a stalled result must block the input.
  `ACC_ALU_ASSERT_SAME(a_backpressure, clk, rst_n, s1_valid_r && out_valid_r && !out_ready, !in_ready, "input accepted while both stages are blocked")

endmodule

[tb/sv/acc_alu_tb_pkg.sv]
// Result type and scoreboard class for the accumulator ALU testbench.
package acc_alu_tb_pkg;
  timeunit 1ns;
  timeprecision 1ps;

  import acc_alu_pkg::*;

  typedef struct packed {
    logic [7:0]  acc;
    logic [7:0]  byte_res;
    logic [15:0] pair_res;
    logic        zero;
    logic        sign;
    logic        parity;
    logic        carry;
    logic        aux_carry;
  } alu_result_t;

  class alu_result_tracker;
    acc_alu_state_t arch;
    alu_result_t    pending_results[$];
    int unsigned    error_count;

    function new();
      arch        = '0;
      error_count = 0;
    endfunction

    function void set_zsp(logic [7:0] v);
      arch.zero   = (v == 8'h00);
      arch.sign   = v[7];
      arch.parity = ~^v;
    endfunction

    // Advance the accumulator and flags for one accepted item and queue its result.
    function void apply_op(logic [3:0] op, logic [7:0] operand, logic [15:0] pair,
                           logic [15:0] hl);
      logic [8:0]  sum9;
      logic [4:0]  nibble_sum;
      logic [7:0]  diff;
      logic [16:0] sum17;
      alu_result_t res;
      res = '0;
      case (op)
        OP_ADD: begin
          sum9           = {1'b0, arch.acc} + {1'b0, operand};
          nibble_sum     = {1'b0, arch.acc[3:0]} + {1'b0, operand[3:0]};
          arch.carry     = sum9[8];
          arch.aux_carry = nibble_sum[4];
          arch.acc       = sum9[7:0];
          set_zsp(arch.acc);
        end
        OP_SUB, OP_CMP: begin
          diff           = arch.acc - operand;
          arch.carry     = (arch.acc < operand);
          arch.aux_carry = (arch.acc[3:0] >= operand[3:0]);
          set_zsp(diff);
          if (op == OP_SUB) begin
            arch.acc = diff;
          end
        end
        OP_AND, OP_XOR, OP_OR: begin
          if (op == OP_AND) begin
            arch.acc = arch.acc & operand;
          end else if (op == OP_XOR) begin
            arch.acc = arch.acc ^ operand;
          end else begin
            arch.acc = arch.acc | operand;
          end
          set_zsp(arch.acc);
          arch.carry     = 1'b0;
          arch.aux_carry = 1'b0;
        end
        OP_INR: begin
          res.byte_res   = operand + 8'd1;
          arch.aux_carry = (operand[3:0] == 4'hF);
          set_zsp(res.byte_res);
        end
        OP_DCR: begin
          res.byte_res   = operand - 8'd1;
          arch.aux_carry = (operand[3:0] != 4'h0);
          set_zsp(res.byte_res);
        end
        OP_INX: begin
          res.pair_res = pair + 16'd1;
        end
        OP_DCX: begin
          res.pair_res = pair - 16'd1;
        end
        OP_DAD: begin
          sum17        = {1'b0, hl} + {1'b0, pair};
          arch.carry   = sum17[16];
          res.pair_res = sum17[15:0];
        end
        default: begin
        end
      endcase
      res.acc       = arch.acc;
      res.zero      = arch.zero;
      res.sign      = arch.sign;
      res.parity    = arch.parity;
      res.carry     = arch.carry;
      res.aux_carry = arch.aux_carry;
      pending_results.push_back(res);
    endfunction

    function void compare(string field, logic [15:0] exp_v, logic [15:0] act_v);
      if (exp_v !== act_v) begin
        error_count++;
        $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                 $time, field, exp_v, act_v);
      end
    endfunction

    function void check_result(alu_result_t act);
      alu_result_t exp_r;
      if (pending_results.size() == 0) begin
        error_count++;
        $display("%0t ns: result with no item outstanding, expected none, actual 0x%0h",
                 $time, act);
        return;
      end
      exp_r = pending_results.pop_front();
      compare("acc_out",        16'(exp_r.acc),       16'(act.acc));
      compare("byte_result",    16'(exp_r.byte_res),  16'(act.byte_res));
      compare("pair_result",    exp_r.pair_res,       act.pair_res);
      compare("zero_flag",      16'(exp_r.zero),      16'(act.zero));
      compare("sign_flag",      16'(exp_r.sign),      16'(act.sign));
      compare("parity_flag",    16'(exp_r.parity),    16'(act.parity));
      compare("carry_flag",     16'(exp_r.carry),     16'(act.carry));
      compare("aux_carry_flag", 16'(exp_r.aux_carry), 16'(act.aux_carry));
    endfunction

    function int unsigned outstanding();
      return pending_results.size();
    endfunction
  endclass

endpackage

[tb/sv/accumulator_alu_with_flags_test.sv]
// Top-level testbench for the accumulator ALU with flags.
module accumulator_alu_with_flags_test;
  timeunit 1ns;
  timeprecision 1ps;

  import acc_alu_pkg::*;
  import acc_alu_tb_pkg::*;

  // Opcodes above DAD are undefined and must leave all state alone.
  localparam logic [3:0] OP_FIRST_UNUSED = OP_DAD + 4'd1;
  localparam logic [3:0] OP_LAST_UNUSED  = 4'hF;
  localparam int         RANDOM_ITEMS    = 1050;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [3:0]  in_req_type = '0;
  logic [7:0]  in_operand = '0;
  logic [15:0] in_pair_value = '0;
  logic [15:0] in_hl_value = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_acc_out;
  logic [7:0]  out_byte_result;
  logic [15:0] out_pair_result;
  logic        out_zero_flag;
  logic        out_sign_flag;
  logic        out_parity_flag;
  logic        out_carry_flag;
  logic        out_aux_carry_flag;

  // Cleared for a stretch of the random part so both sides run flat out.
  bit gaps_on = 1'b1;

  alu_result_tracker tracker = new();

  accumulator_alu_with_flags u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_req_type        (in_req_type),
    .in_operand         (in_operand),
    .in_pair_value      (in_pair_value),
    .in_hl_value        (in_hl_value),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_acc_out        (out_acc_out),
    .out_byte_result    (out_byte_result),
    .out_pair_result    (out_pair_result),
    .out_zero_flag      (out_zero_flag),
    .out_sign_flag      (out_sign_flag),
    .out_parity_flag    (out_parity_flag),
    .out_carry_flag     (out_carry_flag),
    .out_aux_carry_flag (out_aux_carry_flag)
  );

  always #6 clk = ~clk;

  // Result side: stall now and then on the falling edge, so a stall can land on
  // any cycle of the two-stage pipe and back-pressure the input stage.
  always @(negedge clk) begin
    out_ready <= !(gaps_on && $urandom_range(0, 99) < 10);
  end

  // Check every accepted result against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      tracker.check_result('{acc: out_acc_out, byte_res: out_byte_result,
                             pair_res: out_pair_result, zero: out_zero_flag,
                             sign: out_sign_flag, parity: out_parity_flag,
                             carry: out_carry_flag, aux_carry: out_aux_carry_flag});
    end
  end

  // Present one item from a falling edge, hold it until accepted, then note it
  // with the tracker. Returns on the falling edge after acceptance so the next
  // item can follow back to back without lowering valid.
  task automatic send_item(logic [3:0] op, logic [7:0] operand, logic [15:0] pair,
                           logic [15:0] hl);
    while (gaps_on && $urandom_range(0, 99) < 10) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_req_type   <= op;
    in_operand    <= operand;
    in_pair_value <= pair;
    in_hl_value   <= hl;
    do begin
      @(posedge clk);
    end while (!in_ready);
    tracker.apply_op(op, operand, pair, hl);
    @(negedge clk);
  endtask

  // Bias towards the extremes, where carries and wraps live.
  function automatic logic [7:0] pick_byte();
    int unsigned roll;
    roll = $urandom_range(0, 15);
    if (roll == 0) begin
      return 8'h00;
    end else if (roll == 1) begin
      return 8'hFF;
    end else if (roll == 2) begin
      return 8'h80;
    end
    return 8'($urandom());
  endfunction

  function automatic logic [15:0] pick_word();
    int unsigned roll;
    roll = $urandom_range(0, 15);
    if (roll == 0) begin
      return 16'h0000;
    end else if (roll == 1) begin
      return 16'hFFFF;
    end else if (roll == 2) begin
      return 16'h8000;
    end
    return 16'($urandom());
  endfunction

  // Short directed pass: extremes of each field, every opcode, the compare,
  // decrement aux carry and undefined opcode cases.
  task automatic run_directed();
    send_item(OP_ADD, 8'h00, 16'($urandom()), 16'($urandom()));  // zero result from reset
    send_item(OP_ADD, 8'hFF, 16'($urandom()), 16'($urandom()));
    send_item(OP_ADD, 8'h01, 16'($urandom()), 16'($urandom()));  // wrap to zero, both carries
    send_item(OP_SUB, 8'h01, 16'($urandom()), 16'($urandom()));  // borrow
    send_item(OP_CMP, 8'hFF, 16'($urandom()), 16'($urandom()));  // equal, acc kept
    send_item(OP_CMP, 8'h00, 16'($urandom()), 16'($urandom()));
    send_item(OP_SUB, 8'h00, 16'($urandom()), 16'($urandom()));
    send_item(OP_AND, 8'h0F, 16'($urandom()), 16'($urandom()));
    send_item(OP_XOR, 8'hFF, 16'($urandom()), 16'($urandom()));
    send_item(OP_OR,  8'h80, 16'($urandom()), 16'($urandom()));
    send_item(OP_INR, 8'hFF, 16'($urandom()), 16'($urandom()));  // wrap, aux carry
    send_item(OP_INR, 8'h0F, 16'($urandom()), 16'($urandom()));
    send_item(OP_DCR, 8'h00, 16'($urandom()), 16'($urandom()));  // low nibble zero
    send_item(OP_DCR, 8'h10, 16'($urandom()), 16'($urandom()));
    send_item(OP_DCR, 8'h01, 16'($urandom()), 16'($urandom()));
    send_item(OP_INX, 8'($urandom()), 16'hFFFF, 16'($urandom()));
    send_item(OP_INX, 8'($urandom()), 16'h0000, 16'($urandom()));
    send_item(OP_DCX, 8'($urandom()), 16'h0000, 16'($urandom()));
    send_item(OP_DCX, 8'($urandom()), 16'hFFFF, 16'($urandom()));
    send_item(OP_DAD, 8'($urandom()), 16'hFFFF, 16'hFFFF);      // carry out of bit 15
    send_item(OP_DAD, 8'($urandom()), 16'h0000, 16'h0000);
    send_item(OP_DAD, 8'($urandom()), 16'h8000, 16'h8000);
    send_item(OP_FIRST_UNUSED, 8'hFF, 16'hFFFF, 16'hFFFF);       // undefined: no change
    send_item(OP_LAST_UNUSED, 8'h00, 16'h0000, 16'h0000);
  endtask

  // Random pass: mostly defined opcodes with a sprinkling of undefined ones,
  // and a run in the middle with no idling on either side.
  task automatic run_random();
    logic [3:0] op;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      gaps_on = !(n >= 400 && n < 650);
      if ($urandom_range(0, 99) < 5) begin
        op = 4'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED));
      end else begin
        op = 4'($urandom_range(OP_ADD, OP_DAD));
      end
      send_item(op, pick_byte(), pick_word(), pick_word());
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    run_directed();
    run_random();
    in_valid <= 1'b0;
    // Drain the pipe, then wait for any stray result to show up.
    while (tracker.outstanding() != 0) begin
      @(posedge clk);
    end
    repeat (8) @(posedge clk);
    if (tracker.error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #5ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
